>>> rtl/eis_pkg.sv
`default_nettype none

package eis_pkg;

   localparam int COORD_FRAC_BITS = 4;

   localparam int IN_W   = 20;
   localparam int COEF_W = 32;
   localparam int OPD_W  = 33;
   localparam int PRD_W  = 2 * OPD_W;
   localparam int LINE_W = 56;
   localparam int DM_W   = 54;
   localparam int DSQ_W  = 2 * DM_W;
   localparam int NRM_W  = 64;
   localparam int QUO_W  = 41;
   localparam int PRE_SH = (2 * COORD_FRAC_BITS <= 8) ? 8 - 2 * COORD_FRAC_BITS : 0;
   localparam int POST_SH = (2 * COORD_FRAC_BITS > 8) ? 2 * COORD_FRAC_BITS - 8 : 0;
   localparam int DIV_W  = DSQ_W + PRE_SH;

   localparam logic [31:0] ERR_MAX   = 32'hFFFF_FFFF;
   localparam logic [47:0] SCORE_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [31:0] THRESH_RESET = 32'd2304;

   typedef enum logic [2:0] {
      CSR_PAIR_A = 3'd0,
      CSR_PAIR_B = 3'd1,
      CSR_PAIR_C = 3'd2,
      CSR_PAIR_D = 3'd3,
      CSR_LAST   = 3'd4,
      CSR_THRESH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [IN_W-1:0] first_x;
      logic signed [IN_W-1:0] first_y;
      logic signed [IN_W-1:0] second_x;
      logic signed [IN_W-1:0] second_y;
      logic                   restart;
   } req_type;

   typedef struct packed {
      logic        inlier;
      logic [31:0] sq_error;
      logic [47:0] score_total;
      logic [15:0] inlier_count;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [NRM_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] result;
   } div_stat_type;

endpackage

`default_nettype wire

>>> rtl/epipolar_inlier_scoring.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_payload (req_type)
// rsp       out        rsp_valid/rsp_ready    rsp_payload (rsp_type)
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// Each epipolar line runs on the shared 33x33 multiplier and the divider:
// six multiply steps, zero to twenty-one normalising shifts, seven multiply steps,
// one divider start and a 41-step restoring divider. A line with zero norm skips the
// divider, and a saturating quotient skips the divide steps; req_ready rises the cycle
// after the response is taken.
// Reset is synchronous and active high; totals clear, threshold returns to 9 px^2.
// req_ready is low from acceptance until the response is taken; csr is always ready.
`default_nettype none

module epipolar_inlier_scoring
   import eis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_LINE   = 10'b00_0000_0010,
      S_NORM   = 10'b00_0000_0100,
      S_NSQ    = 10'b00_0000_1000,
      S_DOT    = 10'b00_0001_0000,
      S_SQ     = 10'b00_0010_0000,
      S_DSTART = 10'b00_0100_0000,
      S_DIV    = 10'b00_1000_0000,
      S_FIN    = 10'b01_0000_0000,
      S_RESP   = 10'b10_0000_0000
   } state_type;

   function automatic logic [LINE_W-1:0] mag_of(input logic signed [LINE_W-1:0] v);
      return v[LINE_W-1] ? LINE_W'(-v) : LINE_W'(v);
   endfunction

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic line_ff, line_in;
   logic bad_ff, bad_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic [63:0] pair_a_ff, pair_b_ff, pair_c_ff, pair_d_ff;
   logic [31:0] last_ff, thresh_ff;
   logic [47:0] score_ff, score_in;
   logic [15:0] count_ff, count_in;
   logic signed [LINE_W-1:0] acc_ff, acc_in;
   logic signed [LINE_W-1:0] l_ff [3];
   logic signed [LINE_W-1:0] l_in [3];
   logic [LINE_W-1:0] mm_ff, mm_in;
   logic [NRM_W-1:0] n_ff, n_in;
   logic [DM_W-1:0] dm_ff, dm_in;
   logic [DSQ_W-1:0] dsq_ff, dsq_in;
   logic [31:0] e_ff [2];
   logic [31:0] e_in [2];

   logic signed [COEF_W-1:0] f [9];
   logic signed [COEF_W-1:0] g [9];
   logic signed [IN_W-1:0] px, py, qx, qy;
   logic [1:0] k;
   logic [3:0] base;
   logic signed [OPD_W-1:0] opd_a, opd_b;
   logic signed [PRD_W-1:0] product;
   logic signed [LINE_W-1:0] lsum, dsum;
   logic [31:0] err;
   logic inl;
   logic [48:0] score_sum;
   logic line_done;
   logic [31:0] line_err;
   logic line_bad;
   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   eis_mul u_mul (
      .opd_a   (opd_a),
      .opd_b   (opd_b),
      .product (product)
   );

   eis_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   always_comb begin
      f[0] = pair_a_ff[31:0];
      f[1] = pair_a_ff[63:32];
      f[2] = pair_b_ff[31:0];
      f[3] = pair_b_ff[63:32];
      f[4] = pair_c_ff[31:0];
      f[5] = pair_c_ff[63:32];
      f[6] = pair_d_ff[31:0];
      f[7] = pair_d_ff[63:32];
      f[8] = last_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            g[3*r+c] = line_ff ? f[3*c+r] : f[3*r+c];
         end
      end
      px = line_ff ? req_ff.second_x : req_ff.first_x;
      py = line_ff ? req_ff.second_y : req_ff.first_y;
      qx = line_ff ? req_ff.first_x : req_ff.second_x;
      qy = line_ff ? req_ff.first_y : req_ff.second_y;
   end

   assign k    = step_ff[2:1];
   assign base = 4'({2'b00, k}) * 4'd3;

   always_comb begin
      opd_a = '0;
      opd_b = '0;
      unique case (state_ff)
         S_LINE: begin
            if (!step_ff[0]) begin
               opd_a = OPD_W'(g[base]);
               opd_b = OPD_W'(px);
            end else begin
               opd_a = OPD_W'(g[base + 4'd1]);
               opd_b = OPD_W'(py);
            end
         end
         S_NSQ: begin
            opd_a = step_ff[0] ? OPD_W'(signed'(l_ff[1][31:0]))
                               : OPD_W'(signed'(l_ff[0][31:0]));
            opd_b = opd_a;
         end
         S_DOT: begin
            opd_a = step_ff[0] ? OPD_W'(signed'(l_ff[1][31:0]))
                               : OPD_W'(signed'(l_ff[0][31:0]));
            opd_b = step_ff[0] ? OPD_W'(qy) : OPD_W'(qx);
         end
         S_SQ: begin
            opd_a = (step_ff == 3'd2) ? OPD_W'({1'b0, dm_ff[DM_W-1:32]})
                                      : OPD_W'({1'b0, dm_ff[31:0]});
            opd_b = (step_ff == 3'd0) ? OPD_W'({1'b0, dm_ff[31:0]})
                                      : OPD_W'({1'b0, dm_ff[DM_W-1:32]});
         end
         default: begin
            opd_a = '0;
            opd_b = '0;
         end
      endcase
   end

   assign lsum = acc_ff + LINE_W'(product)
               + (LINE_W'(g[base + 4'd2]) <<< COORD_FRAC_BITS);
   assign dsum = acc_ff + LINE_W'(product) + (l_ff[2] <<< COORD_FRAC_BITS);

   assign div_ctrl.start    = (state_ff == S_DSTART) && (n_ff != '0);
   assign div_ctrl.dividend = DIV_W'(dsq_ff) << PRE_SH;
   assign div_ctrl.divisor  = n_ff;

   always_comb begin
      err       = (bad_ff || !(e_ff[0] <= e_ff[1])) ? (bad_ff ? ERR_MAX : e_ff[0]) : e_ff[1];
      inl       = !bad_ff && (err < thresh_ff);
      score_sum = {1'b0, score_ff} + 49'(err);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      line_in  = line_ff;
      bad_in   = bad_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      score_in = score_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      l_in     = l_ff;
      mm_in    = mm_ff;
      n_in     = n_ff;
      dm_in    = dm_ff;
      dsq_in   = dsq_ff;
      e_in     = e_ff;
      line_done = 1'b0;
      line_err  = ERR_MAX;
      line_bad  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               line_in  = 1'b0;
               bad_in   = 1'b0;
               step_in  = '0;
               mm_in    = '0;
               state_in = S_LINE;
               if (req_payload.restart) begin
                  score_in = '0;
                  count_in = '0;
               end
            end
         end
         S_LINE: begin
            if (!step_ff[0]) begin
               acc_in  = LINE_W'(product);
               step_in = step_ff + 3'd1;
            end else begin
               l_in[k] = lsum;
               mm_in   = mm_ff | mag_of(lsum);
               if (step_ff == 3'd5) begin
                  step_in  = '0;
                  state_in = S_NORM;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         S_NORM: begin
            if ((mm_ff >> 31) != '0) begin
               for (int i = 0; i < 3; i++) begin
                  l_in[i] = l_ff[i] >>> 1;
               end
               mm_in = mm_ff >> 1;
            end else begin
               state_in = S_NSQ;
            end
         end
         S_NSQ: begin
            if (!step_ff[0]) begin
               n_in    = product[NRM_W-1:0];
               step_in = 3'd1;
            end else begin
               n_in     = n_ff + product[NRM_W-1:0];
               step_in  = '0;
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            if (!step_ff[0]) begin
               acc_in  = LINE_W'(product);
               step_in = 3'd1;
            end else begin
               dm_in    = DM_W'(mag_of(dsum));
               step_in  = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            unique case (step_ff)
               3'd0: begin
                  dsq_in  = DSQ_W'(product[63:0]);
                  step_in = 3'd1;
               end
               3'd1: begin
                  dsq_in  = dsq_ff + (DSQ_W'(product[63:0]) << 33);
                  step_in = 3'd2;
               end
               default: begin
                  dsq_in   = dsq_ff + (DSQ_W'(product[63:0]) << 64);
                  step_in  = '0;
                  state_in = S_DSTART;
               end
            endcase
         end
         S_DSTART: begin
            if (n_ff == '0) begin
               line_done = 1'b1;
               line_bad  = 1'b1;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               line_done = 1'b1;
               line_err  = div_stat.result;
            end
         end
         S_FIN: begin
            rsp_in.inlier   = inl;
            rsp_in.sq_error = err;
            if (inl) begin
               score_in = score_sum[48] ? SCORE_MAX : score_sum[47:0];
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
            end
            rsp_in.score_total  = score_in;
            rsp_in.inlier_count = count_in;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (line_done) begin
         e_in[line_ff] = line_err;
         bad_in        = bad_ff | line_bad;
         step_in       = '0;
         mm_in         = '0;
         if (!line_ff) begin
            line_in  = 1'b1;
            state_in = S_LINE;
         end else begin
            state_in = S_FIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         line_ff   <= 1'b0;
         bad_ff    <= 1'b0;
         score_ff  <= '0;
         count_ff  <= '0;
         pair_a_ff <= '0;
         pair_b_ff <= '0;
         pair_c_ff <= '0;
         pair_d_ff <= '0;
         last_ff   <= '0;
         thresh_ff <= THRESH_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         line_ff  <= line_in;
         bad_ff   <= bad_in;
         score_ff <= score_in;
         count_ff <= count_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PAIR_A: pair_a_ff <= csr_data;
               CSR_PAIR_B: pair_b_ff <= csr_data;
               CSR_PAIR_C: pair_c_ff <= csr_data;
               CSR_PAIR_D: pair_d_ff <= csr_data;
               CSR_LAST:   last_ff   <= csr_data[31:0];
               CSR_THRESH: thresh_ff <= csr_data[31:0];
               default: begin
               end
            endcase
         end
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      l_ff   <= l_in;
      mm_ff  <= mm_in;
      n_ff   <= n_in;
      dm_ff  <= dm_in;
      dsq_ff <= dsq_in;
      e_ff   <= e_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

`ifndef NO_ASSERTIONS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready did not drop after a request");
   a_inlier_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.inlier) |->
         (rsp_payload.sq_error != ERR_MAX) && (rsp_payload.inlier_count != '0))
      else $error("inlier with saturated error or zero count");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

>>> rtl/eis_mul.sv
`default_nettype none

module eis_mul
   import eis_pkg::*;
(
   input  logic signed [OPD_W-1:0] opd_a,
   input  logic signed [OPD_W-1:0] opd_b,
   output logic signed [PRD_W-1:0] product
);

   assign product = PRD_W'(opd_a) * PRD_W'(opd_b);

endmodule

`default_nettype wire

>>> rtl/eis_div.sv
`default_nettype none

module eis_div
   import eis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);

   localparam int HI_W  = DIV_W - QUO_W;
   localparam int CMP_W = HI_W + NRM_W;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sat_ff, sat_in;
   logic [NRM_W-1:0] rem_ff, rem_in;
   logic [NRM_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] dq_ff, dq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HI_W-1:0]  top_part;
   logic [NRM_W:0]   trial;
   logic [NRM_W:0]   diff;
   logic             ge;
   logic [QUO_W-1:0] quo_sh;

   always_comb begin
      top_part = ctrl.dividend[DIV_W-1:QUO_W];
      trial    = {rem_ff, dq_ff[QUO_W-1]};
      diff     = trial - {1'b0, den_ff};
      ge       = (trial >= {1'b0, den_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sat_in   = sat_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      dq_in    = dq_ff;
      cnt_in   = cnt_ff;
      if (ctrl.start) begin
         den_in = ctrl.divisor;
         dq_in  = ctrl.dividend[QUO_W-1:0];
         cnt_in = CNT_W'(QUO_W);
         if (CMP_W'(top_part) >= CMP_W'(ctrl.divisor)) begin
            sat_in  = 1'b1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            sat_in  = 1'b0;
            busy_in = 1'b1;
            rem_in  = top_part[NRM_W-1:0];
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[NRM_W-1:0] : trial[NRM_W-1:0];
         dq_in  = {dq_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      sat_ff <= sat_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      dq_ff  <= dq_in;
   end

   assign quo_sh      = dq_ff >> POST_SH;
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign stat.result = (sat_ff || (quo_sh[QUO_W-1:32] != '0)) ? ERR_MAX : quo_sh[31:0];

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb
   import eis_pkg::*;
();

   localparam int LIMIT = 3000000;
   localparam int HOLD_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   epipolar_inlier_scoring i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   req_type     pending_q[$];
   rsp_type     score_q[$];

   logic [63:0] coef_pair [4] = '{default: '0};
   logic [31:0] coef_last_r = '0;
   logic [31:0] thresh_r = THRESH_RESET;
   logic [47:0] score_acc = '0;
   logic [15:0] count_acc = '0;

   int          err_cnt = 0;
   int          cycles = 0;
   int          rsp_cnt = 0;
   int          inlier_seen = 0;
   int          csr_cnt = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          hold_left = 0;
   bit          held = 1'b0;
   bit          no_idle = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic [32:0] line_dist(input longint g [9], input longint px,
                                             input longint py, input longint qx,
                                             input longint qy);
      longint      one;
      longint      l [3];
      longint      m;
      longint      mg;
      longint      d;
      int          s;
      logic [63:0] n;
      logic [63:0] dm;
      logic [127:0] dd;
      logic [127:0] q;
      one = longint'(1) <<< COORD_FRAC_BITS;
      m = 0;
      for (int k = 0; k < 3; k++) begin
         l[k] = g[3*k] * px + g[3*k+1] * py + g[3*k+2] * one;
         mg = (l[k] < 0) ? -l[k] : l[k];
         if (mg > m) m = mg;
      end
      s = 0;
      while ((m >> s) >= 64'sh8000_0000) s++;
      for (int k = 0; k < 3; k++) l[k] = l[k] >>> s;
      n = l[0] * l[0] + l[1] * l[1];
      if (n == 0) return {1'b0, ERR_MAX};
      d = qx * l[0] + qy * l[1] + l[2] * one;
      dm = (d < 0) ? -d : d;
      dd = {64'd0, dm} * {64'd0, dm};
      dd = dd << PRE_SH;
      q = (dd / {64'd0, n}) >> POST_SH;
      return {1'b1, (q > {96'd0, ERR_MAX}) ? ERR_MAX : q[31:0]};
   endfunction

   function automatic rsp_type score_match(req_type r);
      longint  f [9];
      longint  ft [9];
      logic [32:0] e1;
      logic [32:0] e2;
      logic [31:0] err;
      logic        inl;
      logic [48:0] sum;
      rsp_type     o;
      for (int k = 0; k < 4; k++) begin
         f[2*k]   = longint'($signed(coef_pair[k][31:0]));
         f[2*k+1] = longint'($signed(coef_pair[k][63:32]));
      end
      f[8] = longint'($signed(coef_last_r));
      for (int rr = 0; rr < 3; rr++)
         for (int c = 0; c < 3; c++) ft[3*rr+c] = f[3*c+rr];
      if (r.restart) begin
         score_acc = '0;
         count_acc = '0;
      end
      e1 = line_dist(f, r.first_x, r.first_y, r.second_x, r.second_y);
      e2 = line_dist(ft, r.second_x, r.second_y, r.first_x, r.first_y);
      if (e1[32] && e2[32]) begin
         err = (e1[31:0] > e2[31:0]) ? e1[31:0] : e2[31:0];
         inl = err < thresh_r;
      end else begin
         err = ERR_MAX;
         inl = 1'b0;
      end
      if (inl) begin
         sum = {1'b0, score_acc} + {17'd0, err};
         score_acc = sum[48] ? SCORE_MAX : sum[47:0];
         if (count_acc != COUNT_MAX) count_acc = count_acc + 16'd1;
      end
      o.inlier = inl;
      o.sq_error = err;
      o.score_total = score_acc;
      o.inlier_count = count_acc;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) score_q = {score_q, score_match(req_payload)};
         if (csr_valid && csr_ready) begin
            csr_cnt <= csr_cnt + 1;
            case (csr_index)
               CSR_PAIR_A: coef_pair[0] <= csr_data;
               CSR_PAIR_B: coef_pair[1] <= csr_data;
               CSR_PAIR_C: coef_pair[2] <= csr_data;
               CSR_PAIR_D: coef_pair[3] <= csr_data;
               CSR_LAST:   coef_last_r <= csr_data[31:0];
               CSR_THRESH: thresh_r <= csr_data[31:0];
               default: ;
            endcase
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_q.size() > 0) begin
            req_payload <= pending_q.pop_front();
            req_valid <= 1'b1;
            req_gap <= no_idle ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_type got;
            rsp_type want;
            got = rsp_payload;
            rsp_cnt <= rsp_cnt + 1;
            if (score_q.size() == 0) begin
               $error("unexpected response %p", got);
               err_cnt++;
            end else begin
               want = score_q.pop_front();
               if (got.inlier) inlier_seen++;
               if (got.inlier !== want.inlier) begin
                  $error("inlier: expected %0d actual %0d", want.inlier, got.inlier);
                  err_cnt++;
               end
               if (got.sq_error !== want.sq_error) begin
                  $error("sq_error: expected %0h actual %0h", want.sq_error, got.sq_error);
                  err_cnt++;
               end
               if (got.score_total !== want.score_total) begin
                  $error("score_total: expected %0h actual %0h",
                         want.score_total, got.score_total);
                  err_cnt++;
               end
               if (got.inlier_count !== want.inlier_count) begin
                  $error("inlier_count: expected %0d actual %0d",
                         want.inlier_count, got.inlier_count);
                  err_cnt++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (rsp_cnt == 300 && !held) begin
            held <= 1'b1;
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
         end else if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 9) == 0) rsp_stall <= pick_gap();
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || score_q.size() > 0 || req_valid) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] coef_scale();
      logic [31:0] v;
      v = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   // kind 0: translation along x, kind 1: along y, kind 2: arbitrary matrix, 3: zero matrix
   task automatic load_matrix(input int kind, input logic [31:0] thr);
      logic [31:0] a;
      logic [31:0] f [9];
      a = coef_scale();
      f = '{default: '0};
      case (kind)
         0: begin f[5] = -a; f[7] = a; end
         1: begin f[2] = a; f[6] = -a; end
         2: for (int k = 0; k < 9; k++) f[k] = $urandom();
         default: ;
      endcase
      csr_write(CSR_PAIR_A, {f[1], f[0]});
      csr_write(CSR_PAIR_B, {f[3], f[2]});
      csr_write(CSR_PAIR_C, {f[5], f[4]});
      csr_write(CSR_PAIR_D, {f[7], f[6]});
      csr_write(CSR_LAST, {$urandom(), f[8]});
      csr_write(CSR_THRESH, {$urandom(), thr});
      csr_write(3'($urandom_range(6, 7)), {$urandom(), $urandom()});
   endtask

   function automatic req_type make_pair(input int kind);
      req_type r;
      logic [19:0] noise;
      r.first_x = IN_W'($urandom());
      r.first_y = IN_W'($urandom());
      r.second_x = IN_W'($urandom());
      r.second_y = IN_W'($urandom());
      r.restart = ($urandom_range(0, 29) == 0);
      noise = 20'($urandom_range(0, 128)) - 20'd64;
      if ($urandom_range(0, 9) < 8) begin
         if (kind == 0) r.second_y = r.first_y + noise;
         else if (kind == 1) r.second_x = r.first_x + noise;
      end
      return r;
   endfunction

   function automatic req_type pt(input int x1, input int y1, input int x2, input int y2,
                                  input bit rs);
      req_type r;
      r.first_x = IN_W'(x1);
      r.first_y = IN_W'(y1);
      r.second_x = IN_W'(x2);
      r.second_y = IN_W'(y2);
      r.restart = rs;
      return r;
   endfunction

   int kinds [8] = '{0, 1, 2, 0, 1, 3, 2, 0};
   logic [31:0] thr;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      pending_q = {pending_q, pt(0, 0, 0, 0, 1'b1)};
      pending_q = {pending_q, pt(-524288, 524287, 524287, -524288, 1'b0)};
      drain();

      load_matrix(0, THRESH_RESET);
      pending_q = {pending_q, pt(100, 200, 300, 200, 1'b0)};
      pending_q = {pending_q, pt(-524288, -524288, 524287, -524288, 1'b0)};
      pending_q = {pending_q, pt(524287, 524287, -524288, 524287, 1'b0)};
      pending_q = {pending_q, pt(0, -524288, 0, 524287, 1'b0)};
      pending_q = {pending_q, pt(-1, -1, -1, -1, 1'b1)};
      pending_q = {pending_q, pt(16, 16, 16, 64, 1'b0)};
      pending_q = {pending_q, pt(5, 7, 9, 7, 1'b0)};
      drain();

      load_matrix(2, 32'hFFFF_FFFF);
      for (int k = 0; k < 8; k++) pending_q = {pending_q, make_pair(2)};
      pending_q = {pending_q, pt(-524288, -524288, -524288, -524288, 1'b0)};
      pending_q = {pending_q, pt(524287, 524287, 524287, 524287, 1'b1)};
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 3))
            0: thr = THRESH_RESET;
            1: thr = '0;
            2: thr = 32'hFFFF_FFFF;
            default: thr = $urandom_range(0, 32'h0001_0000);
         endcase
         load_matrix(kinds[ph], thr);
         no_idle = (ph == 4);
         for (int k = 0; k < 250; k++) pending_q = {pending_q, make_pair(kinds[ph])};
         drain();
      end

      $display("tb: %0d responses checked, %0d inliers, %0d register writes",
               rsp_cnt, inlier_seen, csr_cnt);
      if (err_cnt == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> epipolar_inlier_scoring.f
rtl/eis_pkg.sv
rtl/eis_mul.sv
rtl/eis_div.sv
rtl/epipolar_inlier_scoring.sv
tb/tb.sv
